FILE: rtl/core/stcd_pkg.sv
`timescale 1ns / 1ps
// stcd_pkg: shared types and constants of the spectral tone command detector
// used by every module of the block; depends on nothing

package stcd_pkg;

	// bin index and field widths
	localparam int BIN_W      = 10;
	localparam int CNT_W      = 8;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAME_BINS = 1024;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] FLOOR_RST       = 32'd10000;
	localparam logic [CNT_W-1:0]      HITS_NEEDED_RST = 8'd5;
	localparam logic [BIN_W-1:0]      FIRST_BIN_RST   = 10'd10;
	localparam logic [BIN_W-1:0]      LAST_BIN_RST    = 10'd30;
	localparam logic [BIN_W-1:0]      MOVE_CTR_RST    = 10'd27;
	localparam logic [BIN_W-1:0]      TALK_CTR_RST    = 10'd21;
	localparam logic [BIN_W-1:0]      STOP_CTR_RST    = 10'd24;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOOR       = 3'd0,
		REG_HITS_NEEDED = 3'd1,
		REG_FIRST_BIN   = 3'd2,
		REG_LAST_BIN    = 3'd3,
		REG_MOVE_CTR    = 3'd4,
		REG_TALK_CTR    = 3'd5,
		REG_STOP_CTR    = 3'd6
	} reg_idx_t;

	// operating modes
	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_TALK = 2'd2
	} mode_t;

	// kind of event passed from front to back
	typedef enum logic {
		EV_FRAME = 1'b0,
		EV_CMD   = 1'b1
	} ev_kind_t;

	// one queued event: a finished frame or a mode command
	typedef struct packed {
		ev_kind_t         kind;
		logic             busy;
		logic             peak_valid;
		logic [BIN_W-1:0] peak_bin;
		logic [1:0]       new_mode;
	} event_t;

	// bin within centre-1 .. centre+1, evaluated on 11 bits so the ends clip
	function automatic logic in_band(input logic [BIN_W-1:0] bin,
			input logic [BIN_W-1:0] centre);
		logic [BIN_W:0] b;
		logic [BIN_W:0] c;
		b = {1'b0, bin};
		c = {1'b0, centre};
		return ((b + (BIN_W+1)'(1)) >= c) && (b <= (c + (BIN_W+1)'(1)));
	endfunction

endpackage

FILE: rtl/core/stcd_if.sv
`timescale 1ns / 1ps
// stcd_in_if / stcd_out_if: valid-ready channels of the tone detector
// plain widths, no package dependency

interface stcd_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [9:0]  bin_index;
	logic [31:0] magnitude;
	logic        frame_end;
	logic        music_busy;
	logic [1:0]  new_mode;

	modport source (output valid, cmd, bin_index, magnitude, frame_end, music_busy,
		new_mode, input ready);
	modport sink (input valid, cmd, bin_index, magnitude, frame_end, music_busy,
		new_mode, output ready);
endinterface

interface stcd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       peak_valid;
	logic [9:0] peak_bin;
	logic [7:0] hit_count_out;

	modport source (output valid, mode, peak_valid, peak_bin, hit_count_out,
		input ready);
	modport sink (input valid, mode, peak_valid, peak_bin, hit_count_out,
		output ready);
endinterface

FILE: rtl/core/stcd_front.sv
`timescale 1ns / 1ps
// stcd_front: accepts input words, tracks the frame peak, emits frame and command events
// depends on stcd_pkg and stcd_in_if

module stcd_front #(
	parameter int MAG_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	stcd_in_if.sink                            din,
	input  logic [stcd_pkg::CFG_DATA_W-1:0]    floor_cfg,
	input  logic [stcd_pkg::BIN_W-1:0]         first_bin_cfg,
	input  logic [stcd_pkg::BIN_W-1:0]         last_bin_cfg,
	output logic                               push_valid,
	output stcd_pkg::event_t                   push_ev,
	input  logic                               push_ready
);
	import stcd_pkg::*;

	logic [MAG_WIDTH-1:0] best_mag_q;
	logic [BIN_W-1:0]     best_bin_q;
	logic                 best_found_q;

	logic [MAG_WIDTH+CFG_DATA_W-1:0] mag_ext;
	logic [MAG_WIDTH+CFG_DATA_W-1:0] floor_ext;
	logic [MAG_WIDTH-1:0] mag_m;
	logic [MAG_WIDTH-1:0] floor_m;
	logic                 accept;
	logic                 take_bin;
	logic [BIN_W-1:0]     nxt_bin;
	logic [MAG_WIDTH-1:0] nxt_mag;
	logic                 nxt_found;

	// magnitudes are taken modulo 2^MAG_WIDTH
	assign mag_ext   = {{MAG_WIDTH{1'b0}}, din.magnitude};
	assign floor_ext = {{MAG_WIDTH{1'b0}}, floor_cfg};
	assign mag_m     = mag_ext[MAG_WIDTH-1:0];
	assign floor_m   = floor_ext[MAG_WIDTH-1:0];

	assign din.ready = push_ready;
	assign accept    = din.valid && push_ready;

	// peak compare for the current bin
	always_comb begin
		take_bin = (din.cmd == 1'b0)
			&& (din.bin_index >= first_bin_cfg) && (din.bin_index <= last_bin_cfg)
			&& ({22'd0, din.bin_index} < 32'(FRAME_BINS))
			&& (mag_m > floor_m)
			&& (!best_found_q || (mag_m > best_mag_q));
		nxt_bin   = take_bin ? din.bin_index : best_bin_q;
		nxt_mag   = take_bin ? mag_m : best_mag_q;
		nxt_found = take_bin || best_found_q;
	end

	// event toward the back end
	always_comb begin
		push_valid = accept && (din.cmd || din.frame_end);
		push_ev.kind       = din.cmd ? EV_CMD : EV_FRAME;
		push_ev.busy       = din.music_busy;
		push_ev.peak_valid = nxt_found && !din.music_busy && !din.cmd;
		push_ev.peak_bin   = (nxt_found && !din.music_busy && !din.cmd) ? nxt_bin : '0;
		push_ev.new_mode   = din.new_mode;
	end

	// peak store, cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_mag_q   <= '0;
			best_bin_q   <= '0;
			best_found_q <= 1'b0;
		end else if (accept && !din.cmd) begin
			if (din.frame_end) begin
				best_mag_q   <= '0;
				best_bin_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				best_mag_q   <= nxt_mag;
				best_bin_q   <= nxt_bin;
				best_found_q <= nxt_found;
			end
		end
	end

endmodule

FILE: rtl/core/stcd_queue.sv
`timescale 1ns / 1ps
// stcd_queue: two-entry event queue between front and back
// depends on stcd_pkg

module stcd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  stcd_pkg::event_t push_ev,
	output logic             push_ready,
	output logic             pop_valid,
	output stcd_pkg::event_t pop_ev,
	input  logic             pop_ready
);
	import stcd_pkg::*;

	event_t     ev_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_ev     = ev_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ev_q[wr_ptr_q] <= push_ev;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/core/stcd_back.sv
`timescale 1ns / 1ps
// stcd_back: band decision, hit count, mode register and result word register
// depends on stcd_pkg and stcd_out_if

module stcd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	input  stcd_pkg::event_t             pop_ev,
	output logic                         pop_ready,
	input  logic [stcd_pkg::CNT_W-1:0]   hits_needed_cfg,
	input  logic [stcd_pkg::BIN_W-1:0]   move_ctr_cfg,
	input  logic [stcd_pkg::BIN_W-1:0]   talk_ctr_cfg,
	input  logic [stcd_pkg::BIN_W-1:0]   stop_ctr_cfg,
	stcd_out_if.source                   dout
);
	import stcd_pkg::*;

	mode_t            mode_q;
	logic [CNT_W-1:0] hit_q;
	logic             out_valid_q;
	logic             out_pv_q;
	logic [BIN_W-1:0] out_pb_q;

	logic             do_pop;
	mode_t            mode_nxt;
	logic [CNT_W-1:0] hit_nxt;
	logic [CNT_W-1:0] hit_inc;
	logic             hit;
	mode_t            target;

	assign pop_ready = !out_valid_q || dout.ready;
	assign do_pop    = pop_valid && pop_ready;

	// band decision and count update
	always_comb begin
		mode_nxt = mode_q;
		hit_nxt  = hit_q;
		hit      = 1'b0;
		target   = MODE_STOP;
		hit_inc  = (hit_q != CNT_MAX) ? (hit_q + CNT_W'(1)) : hit_q;
		if (pop_ev.peak_valid && in_band(pop_ev.peak_bin, move_ctr_cfg)) begin
			hit    = 1'b1;
			target = MODE_MOVE;
		end else if (pop_ev.peak_valid && in_band(pop_ev.peak_bin, talk_ctr_cfg)) begin
			hit    = 1'b1;
			target = MODE_TALK;
		end else if (pop_ev.peak_valid && in_band(pop_ev.peak_bin, stop_ctr_cfg)) begin
			hit    = 1'b1;
			target = MODE_STOP;
		end
		unique case (pop_ev.kind)
			EV_CMD: begin
				case (pop_ev.new_mode) inside
					MODE_STOP, MODE_MOVE, MODE_TALK: mode_nxt = mode_t'(pop_ev.new_mode);
					default: mode_nxt = mode_q;
				endcase
			end
			EV_FRAME: begin
				if (!pop_ev.busy) begin
					if (hit) begin
						if (hit_inc >= hits_needed_cfg) begin
							hit_nxt  = '0;
							mode_nxt = target;
						end else begin
							hit_nxt = hit_inc;
						end
					end else begin
						hit_nxt = '0;
					end
				end
			end
			default: mode_nxt = mode_q;
		endcase
	end

	// mode, count and result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOP;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				mode_q      <= mode_nxt;
				hit_q       <= hit_nxt;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			out_pv_q <= pop_ev.peak_valid;
			out_pb_q <= pop_ev.peak_bin;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.mode          = mode_q;
	assign dout.peak_valid    = out_pv_q;
	assign dout.peak_bin      = out_pb_q;
	assign dout.hit_count_out = hit_q;

endmodule

FILE: rtl/core/spectral_tone_command_detector_top.sv
`timescale 1ns / 1ps
// spectral_tone_command_detector_top: configuration registers and front/queue/back
// Throughput: one input word per cycle while the event queue has room; bins that do not end a frame give no result.
// A result word is registered in the event queue and then in the result word register; either can stall.
// The two-entry event queue lets the peak search run on while the result waits.
// Reset: arst_n clears peak store, hit count, mode (stopped), queue and output valid;
// configuration registers return to their documented defaults.

module spectral_tone_command_detector_top #(
	parameter int MAG_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	stcd_in_if.sink                         din,
	stcd_out_if.source                      dout,
	input  logic                            cfg_we,
	input  logic [stcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import stcd_pkg::*;

	logic [CFG_DATA_W-1:0] floor_q;
	logic [CNT_W-1:0]      hits_needed_q;
	logic [BIN_W-1:0]      first_bin_q;
	logic [BIN_W-1:0]      last_bin_q;
	logic [BIN_W-1:0]      move_ctr_q;
	logic [BIN_W-1:0]      talk_ctr_q;
	logic [BIN_W-1:0]      stop_ctr_q;

	logic   push_valid;
	logic   push_ready;
	event_t push_ev;
	logic   pop_valid;
	logic   pop_ready;
	event_t pop_ev;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q       <= FLOOR_RST;
			hits_needed_q <= HITS_NEEDED_RST;
			first_bin_q   <= FIRST_BIN_RST;
			last_bin_q    <= LAST_BIN_RST;
			move_ctr_q    <= MOVE_CTR_RST;
			talk_ctr_q    <= TALK_CTR_RST;
			stop_ctr_q    <= STOP_CTR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLOOR:       floor_q       <= cfg_wdata;
				REG_HITS_NEEDED: hits_needed_q <= cfg_wdata[CNT_W-1:0];
				REG_FIRST_BIN:   first_bin_q   <= cfg_wdata[BIN_W-1:0];
				REG_LAST_BIN:    last_bin_q    <= cfg_wdata[BIN_W-1:0];
				REG_MOVE_CTR:    move_ctr_q    <= cfg_wdata[BIN_W-1:0];
				REG_TALK_CTR:    talk_ctr_q    <= cfg_wdata[BIN_W-1:0];
				REG_STOP_CTR:    stop_ctr_q    <= cfg_wdata[BIN_W-1:0];
				default: ;
			endcase
		end
	end

	// peak search front end
	stcd_front #(
		.MAG_WIDTH(MAG_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.din          (din),
		.floor_cfg    (floor_q),
		.first_bin_cfg(first_bin_q),
		.last_bin_cfg (last_bin_q),
		.push_valid   (push_valid),
		.push_ev      (push_ev),
		.push_ready   (push_ready)
	);

	// event queue
	stcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ev   (push_ev),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_ev    (pop_ev),
		.pop_ready (pop_ready)
	);

	// decision back end
	stcd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ev         (pop_ev),
		.pop_ready      (pop_ready),
		.hits_needed_cfg(hits_needed_q),
		.move_ctr_cfg   (move_ctr_q),
		.talk_ctr_cfg   (talk_ctr_q),
		.stop_ctr_cfg   (stop_ctr_q),
		.dout           (dout)
	);

endmodule

FILE: verif/spectral_tone_command_detector_top_test.sv
`timescale 1ns / 1ps
// spectral_tone_command_detector_top_test: self-checking bench for the tone detector top
// depends on stcd_pkg, stcd_in_if / stcd_out_if and spectral_tone_command_detector_top

// register settings as the bench keeps them
typedef struct {
	logic [31:0] floor_mag;
	logic [7:0]  hits_needed;
	logic [9:0]  first_bin;
	logic [9:0]  last_bin;
	logic [9:0]  move_c;
	logic [9:0]  talk_c;
	logic [9:0]  stop_c;
} cfg_t;

// one input word
typedef struct {
	stcd_pkg::ev_kind_t cmd;
	logic [9:0]         bin;
	logic [31:0]        mag;
	logic               fend;
	logic               busy;
	logic [1:0]         nmode;
} bin_word_t;

// one result word
typedef struct {
	logic [1:0] mode;
	logic       peak_valid;
	logic [9:0] peak_bin;
	logic [7:0] hit_count;
} tone_result_t;

// tone decision predictor and store of expected result words
class tone_scoreboard;
	cfg_t                cfg;
	logic [31:0]         peak_mag;
	logic [9:0]          peak_idx;
	bit                  peak_seen;
	logic [7:0]          hit_cnt;
	stcd_pkg::mode_t     cur_mode;
	tone_result_t        expected_q[$];
	int                  errors;

	function new();
		cfg = '{stcd_pkg::FLOOR_RST, stcd_pkg::HITS_NEEDED_RST, stcd_pkg::FIRST_BIN_RST,
			stcd_pkg::LAST_BIN_RST, stcd_pkg::MOVE_CTR_RST, stcd_pkg::TALK_CTR_RST,
			stcd_pkg::STOP_CTR_RST};
		peak_mag  = '0;
		peak_idx  = '0;
		peak_seen = 0;
		hit_cnt   = '0;
		cur_mode  = stcd_pkg::MODE_STOP;
		errors    = 0;
	endfunction

	// band is centre-1 .. centre+1, clipped at the ends of the bin range
	function bit near(logic [9:0] b, logic [9:0] c);
		int bi;
		int ci;
		bi = int'(b);
		ci = int'(c);
		return bi >= ci - 1 && bi <= ci + 1;
	endfunction

	// shared hit count, saturating; mode switches once enough hits are seen
	function void score_hit(stcd_pkg::mode_t m);
		if (hit_cnt != stcd_pkg::CNT_MAX)
			hit_cnt++;
		if (hit_cnt >= cfg.hits_needed) begin
			hit_cnt  = '0;
			cur_mode = m;
		end
	endfunction

	// accepted input word: update the peak search and queue the result if any
	function void note_word(bin_word_t w);
		tone_result_t r;
		r.peak_valid = 0;
		r.peak_bin   = '0;
		if (w.cmd == stcd_pkg::EV_CMD) begin
			if (w.nmode <= stcd_pkg::MODE_TALK)
				cur_mode = stcd_pkg::mode_t'(w.nmode);
		end else begin
			if (w.bin >= cfg.first_bin && w.bin <= cfg.last_bin && w.mag > cfg.floor_mag &&
					(!peak_seen || w.mag > peak_mag)) begin
				peak_mag  = w.mag;
				peak_idx  = w.bin;
				peak_seen = 1;
			end
			if (!w.fend)
				return;
			// frame decision, skipped while music plays
			if (!w.busy) begin
				if (peak_seen) begin
					r.peak_valid = 1;
					r.peak_bin   = peak_idx;
				end
				if (r.peak_valid && near(peak_idx, cfg.move_c))
					score_hit(stcd_pkg::MODE_MOVE);
				else if (r.peak_valid && near(peak_idx, cfg.talk_c))
					score_hit(stcd_pkg::MODE_TALK);
				else if (r.peak_valid && near(peak_idx, cfg.stop_c))
					score_hit(stcd_pkg::MODE_STOP);
				else
					hit_cnt = '0;
			end
			peak_mag  = '0;
			peak_idx  = '0;
			peak_seen = 0;
		end
		r.mode      = cur_mode;
		r.hit_count = hit_cnt;
		expected_q.push_back(r);
	endfunction

	function void report(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endfunction

	// accepted result word against the oldest expectation
	function void check_word(tone_result_t got);
		tone_result_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: result word with none expected, mode %0d peak_valid %0d peak_bin %0d hits %0d",
				$time, got.mode, got.peak_valid, got.peak_bin, got.hit_count);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (got.mode !== want.mode)
			report("mode", 32'(want.mode), 32'(got.mode));
		if (got.peak_valid !== want.peak_valid)
			report("peak_valid", 32'(want.peak_valid), 32'(got.peak_valid));
		if (got.peak_bin !== want.peak_bin)
			report("peak_bin", 32'(want.peak_bin), 32'(got.peak_bin));
		if (got.hit_count !== want.hit_count)
			report("hit_count_out", 32'(want.hit_count), 32'(got.hit_count));
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module spectral_tone_command_detector_top_test;
	import stcd_pkg::*;

	localparam logic [1:0] MODE_BAD    = 2'd3;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         PHASES      = 8;
	localparam int         PHASE_WORDS = 106;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	stcd_in_if  din();
	stcd_out_if dout();

	tone_scoreboard sb = new();
	cfg_t           cur_cfg;
	int             send_idle_pct;
	int             stall_pct;
	int             quiet;

	spectral_tone_command_detector_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.dout      (dout),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		dout.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// compare result words, note accepted input words
	always @(posedge clk) begin
		if (arst_n) begin
			if (dout.valid && dout.ready)
				sb.check_word('{dout.mode, dout.peak_valid, dout.peak_bin, dout.hit_count_out});
			if (din.valid && din.ready)
				sb.note_word('{ev_kind_t'(din.cmd), din.bin_index, din.magnitude,
					din.frame_end, din.music_busy, din.new_mode});
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready) || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("spectral_tone_command_detector_top regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [9:0] clip10(int v);
		if (v < 0)
			return '0;
		if (v > 1023)
			return 10'd1023;
		return 10'(v);
	endfunction

	// magnitude: tone bins sit above the floor, others anywhere around it
	function automatic logic [31:0] pick_mag(bit tone);
		logic [31:0] head;
		int          r;
		head = 32'hFFFF_FFFF - cur_cfg.floor_mag;
		r = $urandom_range(0, 99);
		if (tone) begin
			if (head == 0 || r < 50)
				return 32'hFFFF_FFFF - $urandom_range(0, 3);
			return cur_cfg.floor_mag + 1 + $urandom_range(0, (head > 1000) ? 999 : head - 1);
		end
		if (r < 30)
			return $urandom;
		if (r < 45)
			return cur_cfg.floor_mag;
		if (r < 60 && head != 0)
			return cur_cfg.floor_mag + 1;
		if (cur_cfg.floor_mag == 0)
			return '0;
		return $urandom_range(0, cur_cfg.floor_mag - 1);
	endfunction

	// bin index mostly in and just around the search window
	function automatic logic [9:0] pick_bin();
		int lo;
		int hi;
		if ($urandom_range(0, 99) < 30)
			return 10'($urandom);
		lo = int'(cur_cfg.first_bin);
		hi = int'(cur_cfg.last_bin);
		if (lo > hi)
			hi = lo;
		return clip10(int'($urandom_range(lo, hi + 2)) - 1);
	endfunction

	function automatic logic [9:0] pick_centre(int first, int span);
		if ($urandom_range(0, 99) < 10)
			return 10'($urandom);
		return clip10(first + int'($urandom_range(0, span)));
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		int   r;
		int   span;
		r = $urandom_range(0, 99);
		if (r < 50)
			c.floor_mag = $urandom_range(0, 20000);
		else if (r < 85)
			c.floor_mag = $urandom;
		else
			c.floor_mag = '0;
		if ($urandom_range(0, 99) < 85)
			c.hits_needed = 8'($urandom_range(0, 4));
		else
			c.hits_needed = 8'($urandom_range(5, 255));
		c.first_bin = 10'($urandom_range(0, 1000));
		if ($urandom_range(0, 99) < 10)
			c.last_bin = 10'($urandom_range(0, int'(c.first_bin)));
		else
			c.last_bin = clip10(int'(c.first_bin) + int'($urandom_range(0, 30)));
		span = (c.last_bin >= c.first_bin) ? int'(c.last_bin - c.first_bin) : 0;
		c.move_c = pick_centre(int'(c.first_bin), span);
		c.talk_c = pick_centre(int'(c.first_bin), span);
		c.stop_c = pick_centre(int'(c.first_bin), span);
		return c;
	endfunction

	// one input word; valid stays high when the next word follows at once
	task automatic send_word(bin_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			din.valid <= 0;
			@(posedge clk);
		end
		din.valid      <= 1;
		din.cmd        <= w.cmd;
		din.bin_index  <= w.bin;
		din.magnitude  <= w.mag;
		din.frame_end  <= w.fend;
		din.music_busy <= w.busy;
		din.new_mode   <= w.nmode;
		@(posedge clk);
		while (!din.ready)
			@(posedge clk);
	endtask

	task automatic send_bin(logic [9:0] bin, logic [31:0] mag, logic fend, logic busy);
		send_word('{EV_FRAME, bin, mag, fend, busy, 2'($urandom)});
	endtask

	task automatic send_cmd(logic [1:0] m);
		send_word('{EV_CMD, 10'($urandom), $urandom, 1'($urandom), 1'($urandom), m});
	endtask

	// all registers written back to back while the block is idle
	task automatic write_all(cfg_t c);
		cfg_we    <= 1;
		cfg_index <= REG_FLOOR;
		cfg_wdata <= c.floor_mag;
		@(posedge clk);
		cfg_index <= REG_HITS_NEEDED;
		cfg_wdata <= 32'(c.hits_needed);
		@(posedge clk);
		cfg_index <= REG_FIRST_BIN;
		cfg_wdata <= 32'(c.first_bin);
		@(posedge clk);
		cfg_index <= REG_LAST_BIN;
		cfg_wdata <= 32'(c.last_bin);
		@(posedge clk);
		cfg_index <= REG_MOVE_CTR;
		cfg_wdata <= 32'(c.move_c);
		@(posedge clk);
		cfg_index <= REG_TALK_CTR;
		cfg_wdata <= 32'(c.talk_c);
		@(posedge clk);
		cfg_index <= REG_STOP_CTR;
		cfg_wdata <= 32'(c.stop_c);
		@(posedge clk);
		cfg_we  <= 0;
		cur_cfg = c;
		sb.cfg  = c;
	endtask

	// wait for every expected word, then let the pipeline settle
	task automatic wait_idle(int settle);
		din.valid <= 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// frames with a tone planted near one band centre, commands and stray words
	task automatic run_traffic(int n);
		int         sent;
		int         len;
		int         pos;
		int         r;
		bit         tone;
		logic [9:0] ctr;
		logic       busy;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_cmd(2'($urandom_range(0, 3)));
				sent++;
			end else if (r < 14) begin
				send_bin(10'($urandom), $urandom, 1'($urandom), 1'($urandom));
				sent++;
			end else begin
				len  = $urandom_range(1, 8);
				pos  = $urandom_range(0, len - 1);
				tone = ($urandom_range(0, 99) < 70);
				case ($urandom_range(0, 2))
					0: ctr = cur_cfg.move_c;
					1: ctr = cur_cfg.talk_c;
					default: ctr = cur_cfg.stop_c;
				endcase
				for (int k = 0; k < len; k++) begin
					// a command in the middle of a frame leaves the search alone
					if ($urandom_range(0, 99) < 4) begin
						send_cmd(2'($urandom_range(0, 3)));
						sent++;
					end
					busy = (k == len - 1) ? ($urandom_range(0, 99) < 15) : 1'($urandom);
					if (tone && k == pos)
						send_bin(clip10(int'(ctr) + int'($urandom_range(0, 4)) - 2),
							pick_mag(1), k == len - 1, busy);
					else
						send_bin(pick_bin(), pick_mag(0), k == len - 1, busy);
					sent++;
				end
			end
		end
	endtask

	initial begin
		cfg_t c;
		arst_n          = 0;
		cfg_we          = 0;
		cfg_index       = REG_FLOOR;
		cfg_wdata       = '0;
		din.valid       = 0;
		din.cmd         = EV_FRAME;
		din.bin_index   = '0;
		din.magnitude   = '0;
		din.frame_end   = 0;
		din.music_busy  = 0;
		din.new_mode    = MODE_STOP;
		dout.ready      = 0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		quiet           = 0;
		cur_cfg         = sb.cfg;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed words under the reset register values
		send_cmd(MODE_MOVE);
		send_cmd(MODE_BAD);
		send_cmd(MODE_TALK);
		send_cmd(MODE_STOP);
		send_bin(10'd0, '1, 0, 1);
		send_bin(10'd27, FLOOR_RST, 0, 0);
		send_bin(10'd26, FLOOR_RST + 1, 0, 0);
		send_bin(10'd27, FLOOR_RST + 1, 0, 0);
		send_cmd(MODE_MOVE);
		send_bin(10'd1023, '1, 1, 0);
		send_bin(10'd28, '1, 1, 1);
		send_bin(10'd22, '0, 1, 0);
		send_bin(10'd20, '1, 1, 0);
		send_bin(10'd30, 32'd50000, 0, 0);
		send_bin(10'd25, 32'd60000, 1, 0);
		send_bin(10'd10, 32'd20000, 1, 0);
		send_cmd(MODE_STOP);
		repeat (5) send_bin(10'd28, 32'h8000_0000, 1, 0);
		wait_idle(4);

		// random phases: extreme settings first, idling pattern rotates
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: c = '{32'd0, 8'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd512};
				1: c = '{32'hFFFF_FFFF, 8'd255, 10'd1023, 10'd0, 10'd1022, 10'd1, 10'd500};
				2: c = '{32'd1000, 8'd1, 10'd5, 10'd40, 10'd20, 10'd20, 10'd21};
				default: c = rand_cfg();
			endcase
			write_all(c);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 83;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 83;
				end
				default: begin
					send_idle_pct = 35;
					stall_pct     = 35;
				end
			endcase
			run_traffic(PHASE_WORDS);
			wait_idle(4);
		end
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("spectral_tone_command_detector_top regression: pass");
		else
			$display("spectral_tone_command_detector_top regression: fail");
		$finish;
	end

endmodule
